@@ rtl/core/threefry2x32_block_generator_defines.svh @@
// Assertion macros shared by the generator RTL.
`ifndef THREEFRY2X32_BLOCK_GENERATOR_DEFINES_SVH
`define THREEFRY2X32_BLOCK_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TF2X32_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TF2X32_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tf2x32_pkg.sv @@
package tf2x32_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Working state of one item as it moves down the pipeline.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t k0;
    word_t k1;
  } lane_t;

  typedef struct packed {
    word_t lo;
    word_t hi;
  } result_t;

  localparam word_t KEY_PARITY = 32'h1BD1_1BDA;

  localparam int unsigned ROT_SCHED [8] = '{13, 15, 26, 6, 17, 29, 16, 24};

  // Rotation amount of a given round; the schedule repeats every eight rounds.
  function automatic int unsigned rot_amt(input int unsigned round_idx);
    logic [2:0] sel;
    sel = round_idx[2:0];
    return ROT_SCHED[sel];
  endfunction

  // Word of the three-word key schedule at a given index.
  function automatic word_t key_word(input word_t k0, input word_t k1,
                                     input int unsigned idx);
    word_t w;
    if (idx == 0) begin
      w = k0;
    end else if (idx == 1) begin
      w = k1;
    end else begin
      w = KEY_PARITY ^ k0 ^ k1;
    end
    return w;
  endfunction

endpackage

@@ rtl/core/tf2x32_mix.sv @@
// One Threefry round: add, rotate by a fixed amount, xor; registered.
module tf2x32_mix #(
  parameter int unsigned ROT_AMT = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tf2x32_pkg::lane_t  lane_i,
  output logic               valid_o,
  output tf2x32_pkg::lane_t  lane_o
);

  localparam int unsigned W = tf2x32_pkg::WORD_W;

  logic              valid_q;
  tf2x32_pkg::lane_t lane_d;
  tf2x32_pkg::lane_t lane_q;
  tf2x32_pkg::word_t b_rot;

  assign b_rot = {lane_i.b[W-1-ROT_AMT:0], lane_i.b[W-1:W-ROT_AMT]};

  always_comb begin
    lane_d    = lane_i;
    lane_d.a  = lane_i.a + lane_i.b;
    lane_d.b  = b_rot ^ lane_d.a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

@@ rtl/core/tf2x32_inject.sv @@
// Key injection number INJ_NUM; registered.
module tf2x32_inject #(
  parameter int unsigned INJ_NUM = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tf2x32_pkg::lane_t  lane_i,
  output logic               valid_o,
  output tf2x32_pkg::lane_t  lane_o
);

  localparam int unsigned A_IDX = INJ_NUM % 3;
  localparam int unsigned B_IDX = (INJ_NUM + 1) % 3;
  localparam tf2x32_pkg::word_t INJ_WORD = tf2x32_pkg::WORD_W'(INJ_NUM);

  logic              valid_q;
  tf2x32_pkg::lane_t lane_d;
  tf2x32_pkg::lane_t lane_q;

  always_comb begin
    lane_d   = lane_i;
    lane_d.a = lane_i.a + tf2x32_pkg::key_word(lane_i.k0, lane_i.k1, A_IDX);
    lane_d.b = lane_i.b + tf2x32_pkg::key_word(lane_i.k0, lane_i.k1, B_IDX) + INJ_WORD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

@@ rtl/core/tf2x32_outq.sv @@
// Output register with one skid entry behind it.
module tf2x32_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tf2x32_pkg::result_t  data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tf2x32_pkg::result_t  data_o
);

  logic                out_valid_d, out_valid_q;
  logic                skid_valid_d, skid_valid_q;
  logic                out_free;
  logic                load_out, load_skid, load_from_skid;
  tf2x32_pkg::result_t out_q;
  tf2x32_pkg::result_t skid_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d    = out_valid_q;
    skid_valid_d   = skid_valid_q;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    load_from_skid = 1'b0;
    if (out_free) begin
      if (skid_valid_q) begin
        load_from_skid = 1'b1;
        out_valid_d    = 1'b1;
        skid_valid_d   = 1'b0;
      end else begin
        load_out    = valid_i;
        out_valid_d = valid_i;
      end
    end else if (valid_i && !skid_valid_q) begin
      load_skid    = 1'b1;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_from_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= data_i;
    end
    if (load_skid) begin
      skid_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

endmodule

@@ rtl/core/threefry2x32_block_generator.sv @@
// From input accept to output valid, an item passes one register per round, one per key
// injection, and the output register.
// Throughput: one item per cycle; the pipeline freezes only while the skid entry is full.
// Reset (asynchronous, active low) clears every valid bit and the skid entry;
// payload registers are not reset.
`include "threefry2x32_block_generator_defines.svh"

module threefry2x32_block_generator #(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] key_lo_i,
  input  logic [31:0] key_hi_i,
  input  logic [31:0] ctr_lo_i,
  input  logic [31:0] ctr_hi_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_lo_o,
  output logic [31:0] out_hi_o
);

  // Stage 1 is the initial key injection. Each round then takes one stage, and every
  // fourth round is followed by its own key injection stage, so no stage holds more
  // than one 32-bit add (two for an injection, one of them a constant).
  localparam int unsigned NUM_STAGES = 1 + ROUND_COUNT + ROUND_COUNT / 4;

  // Index 0 is the input port; index i is the register of stage i.
  logic              valid_w [NUM_STAGES+1];
  tf2x32_pkg::lane_t lane_w  [NUM_STAGES+1];

  logic                skid_full;
  logic                pipe_en;
  tf2x32_pkg::result_t last_result;
  tf2x32_pkg::result_t out_result;

  // The whole pipeline advances together. When the output is stalled, the item leaving
  // the last stage drops into the skid entry, and only then does the pipeline freeze, so
  // the stall signal into the pipe is a register and not a long ready chain.
  assign pipe_en    = !skid_full;
  assign in_stall_o = skid_full;

  assign valid_w[0] = in_valid_i;
  assign lane_w[0]  = '{a: ctr_lo_i, b: ctr_hi_i, k0: key_lo_i, k1: key_hi_i};

  // Injection zero adds the first two key words to the counter words.
  tf2x32_inject #(
    .INJ_NUM (0)
  ) u_inject_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (valid_w[0]),
    .lane_i  (lane_w[0]),
    .valid_o (valid_w[1]),
    .lane_o  (lane_w[1])
  );

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    localparam int unsigned MIX_IDX = 2 + r + r / 4;

    tf2x32_mix #(
      .ROT_AMT (tf2x32_pkg::rot_amt(r))
    ) u_mix (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (valid_w[MIX_IDX-1]),
      .lane_i  (lane_w[MIX_IDX-1]),
      .valid_o (valid_w[MIX_IDX]),
      .lane_o  (lane_w[MIX_IDX])
    );

    // A key injection closes every full group of four rounds. Trailing rounds of an
    // incomplete group get none.
    if ((r + 1) % 4 == 0) begin : g_inject
      tf2x32_inject #(
        .INJ_NUM ((r + 1) / 4)
      ) u_inject (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (pipe_en),
        .valid_i (valid_w[MIX_IDX]),
        .lane_i  (lane_w[MIX_IDX]),
        .valid_o (valid_w[MIX_IDX+1]),
        .lane_o  (lane_w[MIX_IDX+1])
      );
    end
  end

  assign last_result = '{lo: lane_w[NUM_STAGES].a, hi: lane_w[NUM_STAGES].b};

  // The output register decouples the consumer from the pipeline; the skid entry catches
  // the one item that leaves the pipe in the cycle the stall is seen.
  tf2x32_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_w[NUM_STAGES] && pipe_en),
    .data_i      (last_result),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_result)
  );

  assign out_lo_o = out_result.lo;
  assign out_hi_o = out_result.hi;

  // The skid entry only fills behind a valid output item.
  `TF2X32_ASSERT_IMP(a_skid_behind_output, skid_full, out_valid_o,
                     "skid entry holds an item while the output register is empty")
  // A stalled output keeps the skid entry full, so no item is dropped.
  `TF2X32_ASSERT_NXT(a_skid_holds, skid_full && out_stall_i, skid_full,
                     "skid entry drained while the output was stalled")
  // While the input is stalled, the pipeline is frozen and its last stage holds.
  `TF2X32_ASSERT_NXT(a_pipe_frozen, in_stall_o, $stable(valid_w[NUM_STAGES]),
                     "last pipeline stage changed while the pipeline was frozen")

endmodule
